// File: design/iss_pkg.sv
// Shared types and codes for the indexed sequence store.
// No dependencies; the core and the cell import this package.
`default_nettype none

package iss_pkg;

	// Index and count fields that cross between the top level and the cells.
	// Wide enough for a capacity of 256 entries.
	localparam int CNT_W = 9;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [3:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_READ_FRONT = 4'd4,
		OP_READ_BACK  = 4'd5,
		OP_INSERT     = 4'd6,
		OP_REMOVE     = 4'd7,
		OP_FIND       = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_HOLD  = 2'd0,
		MODE_OPEN  = 2'd1,
		MODE_CLOSE = 2'd2
	} mode_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		mode_t mode;
		cnt_t  at;
		cnt_t  cnt;
	} cell_cmd_t;

endpackage

`default_nettype wire

// File: design/iss_if.sv
// Request and response channel interfaces for the indexed sequence store.
// Depends on nothing; widths are fixed by the channel fields.
`default_nettype none

interface iss_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [7:0]  position;
	logic signed [31:0] value;

	modport source (output valid, output opcode, output position, output value, input ready);
	modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface iss_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic signed [31:0] read_value;
	logic [4:0]  found_position;
	logic [4:0]  item_count;
	logic        is_empty;

	modport source (output valid, output status, output read_value, output found_position,
		output item_count, output is_empty, input ready);
	modport sink   (input valid, input status, input read_value, input found_position,
		input item_count, input is_empty, output ready);
endinterface

`default_nettype wire

// File: design/indexed_sequence_store_core.sv
// Top level of the indexed sequence store: request register, command decode,
// the row of iss_cell storage cells, and the response register.
// Depends on iss_pkg, iss_if and iss_cell.
//
//   channel  dir  fields                                              transfer
//   req      in   opcode, position, value                             valid & ready
//   rsp      out  status, read_value, found_position, item_count,     valid & ready
//                 is_empty
//
// A request is registered on transfer and executed once the response register
// is free or being taken, when the whole row shifts or compares at once; its
// response is registered then. Sustained rate is one request per cycle while
// rsp.ready stays high.
// A stalled response holds execution of the pending request, which holds req.
// Reset clears the count and the valid flags; cell contents are not cleared.
`default_nettype none

module indexed_sequence_store_core
	import iss_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	iss_req_if.sink   req,
	iss_rsp_if.source rsp
);

	localparam int   CW      = $clog2(CAPACITY + 1);
	localparam cnt_t CAP_CNT = CNT_W'(CAPACITY);

	// Pending request
	logic               pend_q;
	op_t                opcode_q;
	logic [7:0]         position_q;
	logic signed [31:0] value_q;

	logic [CW-1:0] count_q;

	// Response register
	logic               rsp_valid_q;
	status_t            status_q;
	logic signed [31:0] read_value_q;
	logic [4:0]         found_q;
	logic [4:0]         item_count_q;
	logic               is_empty_q;

	logic exec;
	logic req_xfer;

	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] new_word;
	logic [DATA_WIDTH-1:0] words      [CAPACITY];
	logic [DATA_WIDTH-1:0] back_chain [CAPACITY+1];
	logic                  found_chain[CAPACITY+1];
	cnt_t                  pos_chain  [CAPACITY+1];

	status_t               status_nxt;
	cnt_t                  cnt_cur;
	cnt_t                  cnt_nxt;
	cnt_t                  pos_ext;
	cnt_t                  found_nxt;
	logic [DATA_WIDTH-1:0] rd_word;
	logic signed [63:0]    rd_ext;

	assign exec     = pend_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !pend_q || exec;
	assign req_xfer = req.valid && req.ready;

	assign cnt_cur  = CNT_W'(count_q);
	assign pos_ext  = CNT_W'(position_q);
	assign new_word = DATA_WIDTH'(64'(value_q));

	always_comb begin
		cmd.mode   = MODE_HOLD;
		cmd.at     = '0;
		cmd.cnt    = cnt_cur;
		status_nxt = ST_OK;
		cnt_nxt    = cnt_cur;
		found_nxt  = '0;
		rd_word    = '0;
		case (opcode_q)
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
				if (cnt_cur == CAP_CNT) begin
					status_nxt = ST_FULL;
				end else begin
					cmd.mode = MODE_OPEN;
					if (opcode_q == OP_PUSH_FRONT)
						cmd.at = '0;
					else if (opcode_q == OP_INSERT && pos_ext < cnt_cur)
						cmd.at = pos_ext;
					else
						cmd.at = cnt_cur;
					cnt_nxt = cnt_cur + CNT_W'(1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (cnt_cur == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					cmd.mode = MODE_CLOSE;
					cmd.at   = (opcode_q == OP_POP_FRONT) ? '0 : cnt_cur - CNT_W'(1);
					cnt_nxt  = cnt_cur - CNT_W'(1);
				end
			end
			OP_READ_FRONT, OP_READ_BACK: begin
				if (cnt_cur == '0)
					status_nxt = ST_EMPTY;
				else
					rd_word = (opcode_q == OP_READ_FRONT) ? words[0] : back_chain[CAPACITY];
			end
			OP_REMOVE: begin
				if (pos_ext >= cnt_cur) begin
					status_nxt = ST_BAD_INDEX;
				end else begin
					cmd.mode = MODE_CLOSE;
					cmd.at   = pos_ext;
					cnt_nxt  = cnt_cur - CNT_W'(1);
				end
			end
			OP_FIND: begin
				found_nxt = found_chain[CAPACITY] ? pos_chain[CAPACITY] : cnt_cur;
			end
			default: status_nxt = ST_OK;
		endcase
	end

	assign rd_ext = 64'(signed'(rd_word));

	// Row of cells; the find and read-back chains ripple from cell 0 upward.
	assign back_chain[0]  = '0;
	assign found_chain[0] = 1'b0;
	assign pos_chain[0]   = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] up_w;
		logic [DATA_WIDTH-1:0] dn_w;

		if (i == 0) begin : g_first
			assign up_w = new_word;
		end else begin : g_mid_up
			assign up_w = words[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign dn_w = words[i];
		end else begin : g_mid_dn
			assign dn_w = words[i+1];
		end

		iss_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.INDEX     (i)
		) u_cell (
			.clk      (clk),
			.en       (exec),
			.cmd      (cmd),
			.new_word (new_word),
			.up_word  (up_w),
			.dn_word  (dn_w),
			.word     (words[i]),
			.back_in  (back_chain[i]),
			.back_out (back_chain[i+1]),
			.found_in (found_chain[i]),
			.pos_in   (pos_chain[i]),
			.found_out(found_chain[i+1]),
			.pos_out  (pos_chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_xfer)
				pend_q <= 1'b1;
			else if (exec)
				pend_q <= 1'b0;

			if (exec)
				count_q <= CW'(cnt_nxt);

			if (exec)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			opcode_q   <= op_t'(req.opcode);
			position_q <= req.position;
			value_q    <= req.value;
		end
		if (exec) begin
			status_q     <= status_nxt;
			read_value_q <= 32'(rd_ext);
			found_q      <= 5'(found_nxt);
			item_count_q <= 5'(cnt_nxt);
			is_empty_q   <= (cnt_nxt == '0);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.read_value     = read_value_q;
	assign rsp.found_position = found_q;
	assign rsp.item_count     = item_count_q;
	assign rsp.is_empty       = is_empty_q;

endmodule

`default_nettype wire

// File: design/iss_cell.sv
// One storage cell of the sequence row: holds one word, shifts with its
// neighbors on insert/remove, and joins the find and read-back chains.
// Depends on iss_pkg.
`default_nettype none

module iss_cell
	import iss_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int INDEX      = 0
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire cell_cmd_t             cmd,
	input  wire logic [DATA_WIDTH-1:0] new_word,
	input  wire logic [DATA_WIDTH-1:0] up_word,
	input  wire logic [DATA_WIDTH-1:0] dn_word,
	output logic      [DATA_WIDTH-1:0] word,
	input  wire logic [DATA_WIDTH-1:0] back_in,
	output logic      [DATA_WIDTH-1:0] back_out,
	input  wire logic                  found_in,
	input  wire cnt_t                  pos_in,
	output logic                       found_out,
	output cnt_t                       pos_out
);

	localparam cnt_t MY_IDX = CNT_W'(INDEX);

	logic [DATA_WIDTH-1:0] word_q;
	logic [DATA_WIDTH-1:0] word_nxt;
	logic                  live;
	logic                  hit;

	assign word = word_q;
	assign live = MY_IDX < cmd.cnt;
	assign hit  = live && (word_q == new_word);

	// First hit wins: a cell only claims the position if nothing upstream did.
	assign found_out = found_in | hit;
	assign pos_out   = found_in ? pos_in : MY_IDX;

	assign back_out = back_in | ((MY_IDX == cmd.cnt - CNT_W'(1)) ? word_q : '0);

	always_comb begin
		word_nxt = word_q;
		case (cmd.mode)
			MODE_OPEN: begin
				if (MY_IDX == cmd.at)
					word_nxt = new_word;
				else if (MY_IDX > cmd.at)
					word_nxt = up_word;
			end
			MODE_CLOSE: begin
				if (MY_IDX >= cmd.at)
					word_nxt = dn_word;
			end
			default: word_nxt = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			word_q <= word_nxt;
	end

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for indexed_sequence_store_core: directed and random
// list requests over the req/rsp channels, checked against an in-bench list model.
// Depends on iss_pkg, iss_if and the design sources.

module tb;
	import iss_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_REQS = 1550;
	localparam int PHASE_LEN   = 150;
	localparam int HOLD_CYCLES = 64;

	// Opcodes outside the defined set; the block treats them as no-ops.
	localparam logic [3:0] OP_UNUSED_LO = 4'd9;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;

	typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIX} trend_t;

	typedef struct {
		logic [3:0]         opcode;
		logic [7:0]         position;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct {
		status_t            status;
		logic signed [31:0] read_value;
		logic [4:0]         found_position;
		logic [4:0]         item_count;
		logic               is_empty;
	} rsp_item_t;

	logic clk = 1'b0;
	logic arst_n;

	iss_req_if req_ch ();
	iss_rsp_if rsp_ch ();

	indexed_sequence_store_core #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (32)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	req_item_t pending_requests[$];
	rsp_item_t expected_responses[$];

	logic signed [31:0] list_words[CAPACITY];
	int list_count = 0;

	logic req_taken = 1'b0;
	int   accepted_reqs = 0;
	int   total_reqs = 0;
	int   errors = 0;
	int   quiet_cycles = 0;
	int   hold_left = 0;
	int   hold_at = 50;

	// Next-state model of the list; returns the response the request should produce.
	function automatic rsp_item_t apply_request(req_item_t rq);
		rsp_item_t rs;
		int at;
		int i;
		rs.status = ST_OK;
		rs.read_value = '0;
		rs.found_position = '0;
		case (rq.opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
				if (list_count >= CAPACITY) begin
					rs.status = ST_FULL;
				end else begin
					at = (rq.opcode == OP_PUSH_FRONT) ? 0 : list_count;
					// insert past the end appends
					if (rq.opcode == OP_INSERT && int'(rq.position) < list_count)
						at = int'(rq.position);
					for (i = list_count; i > at; i--)
						list_words[i] = list_words[i-1];
					list_words[at] = rq.value;
					list_count++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
				if (rq.opcode != OP_REMOVE && list_count == 0) begin
					rs.status = ST_EMPTY;
				end else if (rq.opcode == OP_REMOVE && int'(rq.position) >= list_count) begin
					rs.status = ST_BAD_INDEX;
				end else begin
					at = (rq.opcode == OP_POP_FRONT) ? 0 :
						(rq.opcode == OP_POP_BACK) ? list_count - 1 : int'(rq.position);
					for (i = at; i + 1 < list_count; i++)
						list_words[i] = list_words[i+1];
					list_count--;
				end
			end
			OP_READ_FRONT, OP_READ_BACK: begin
				if (list_count == 0)
					rs.status = ST_EMPTY;
				else
					rs.read_value = list_words[(rq.opcode == OP_READ_FRONT) ? 0 : list_count - 1];
			end
			OP_FIND: begin
				// scan downward so the lowest match wins
				rs.found_position = 5'(list_count);
				for (i = list_count - 1; i >= 0; i--)
					if (list_words[i] == rq.value)
						rs.found_position = 5'(i);
			end
			default: ;
		endcase
		rs.item_count = 5'(list_count);
		rs.is_empty = (list_count == 0);
		return rs;
	endfunction

	function automatic int current_phase();
		return (accepted_reqs / PHASE_LEN) % 4;
	endfunction

	function automatic int sender_idle_pct();
		case (current_phase())
			1: return 50;
			3: return 12;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (current_phase())
			2: return 50;
			3: return 12;
			default: return 0;
		endcase
	endfunction

	// Small pool of repeated values keeps find hitting stored entries.
	function automatic logic signed [31:0] random_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $urandom_range(0, 7) - 3;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_item_t random_request(trend_t trend);
		req_item_t rq;
		int roll;
		roll = $urandom_range(0, 99);
		case (trend)
			TREND_GROW:
				rq.opcode = 4'((roll < 35) ? OP_PUSH_BACK : (roll < 60) ? OP_PUSH_FRONT :
					(roll < 85) ? OP_INSERT : $urandom_range(OP_POP_FRONT, OP_FIND));
			TREND_SHRINK:
				rq.opcode = 4'((roll < 25) ? OP_POP_FRONT : (roll < 50) ? OP_POP_BACK :
					(roll < 80) ? OP_REMOVE : $urandom_range(OP_READ_FRONT, OP_FIND));
			default:
				rq.opcode = 4'($urandom_range(OP_PUSH_FRONT, OP_FIND));
		endcase
		rq.position = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
			$urandom_range(0, 17));
		rq.value = random_word();
		return rq;
	endfunction

	task automatic add_request(logic [3:0] op, logic [7:0] pos, logic signed [31:0] val);
		req_item_t rq;
		rq.opcode = op;
		rq.position = pos;
		rq.value = val;
		pending_requests.insert(pending_requests.size(), rq);
	endtask

	always @(negedge clk) begin : drive_requests
		logic busy;
		req_item_t nxt;
		busy = req_ch.valid && !req_taken;
		if (!busy) begin
			if (arst_n && pending_requests.size() != 0 &&
					$urandom_range(0, 99) >= sender_idle_pct()) begin
				nxt = pending_requests[0];
				pending_requests.delete(0);
				req_ch.valid    <= 1'b1;
				req_ch.opcode   <= nxt.opcode;
				req_ch.position <= nxt.position;
				req_ch.value    <= nxt.value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response back-pressure, with long hold-offs that let the request side back up.
	always @(negedge clk) begin : drive_ready
		logic rdy;
		if (!arst_n) begin
			rdy = 1'b0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			rdy = 1'b0;
		end else if (accepted_reqs >= hold_at) begin
			hold_left = HOLD_CYCLES;
			hold_at = hold_at + 4 * PHASE_LEN;
			rdy = 1'b0;
		end else begin
			rdy = $urandom_range(0, 99) >= receiver_stall_pct();
		end
		rsp_ch.ready <= rdy;
	end

	always @(posedge clk) begin : monitor
		rsp_item_t want;
		logic req_fire;
		logic rsp_fire;
		if (arst_n) begin
			req_fire = req_ch.valid && req_ch.ready;
			rsp_fire = rsp_ch.valid && rsp_ch.ready;
			req_taken <= req_fire;
			if (req_fire) begin
				expected_responses.insert(expected_responses.size(),
					apply_request('{req_ch.opcode, req_ch.position, req_ch.value}));
				accepted_reqs <= accepted_reqs + 1;
			end
			if (rsp_fire) begin
				if (expected_responses.size() == 0) begin
					$display("%0t: response transfer with nothing outstanding", $time);
					errors++;
				end else begin
					want = expected_responses[0];
					expected_responses.delete(0);
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							rsp_ch.status);
						errors++;
					end
					if (rsp_ch.read_value !== want.read_value) begin
						$display("%0t: read_value expected %0d actual %0d", $time,
							want.read_value, rsp_ch.read_value);
						errors++;
					end
					if (rsp_ch.found_position !== want.found_position) begin
						$display("%0t: found_position expected %0d actual %0d", $time,
							want.found_position, rsp_ch.found_position);
						errors++;
					end
					if (rsp_ch.item_count !== want.item_count) begin
						$display("%0t: item_count expected %0d actual %0d", $time,
							want.item_count, rsp_ch.item_count);
						errors++;
					end
					if (rsp_ch.is_empty !== want.is_empty) begin
						$display("%0t: is_empty expected %0d actual %0d", $time,
							want.is_empty, rsp_ch.is_empty);
						errors++;
					end
				end
			end
			if (req_fire || rsp_fire) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("TEST FAILED");
					$finish;
				end
			end
		end else begin
			req_taken <= 1'b0;
		end
	end

	initial begin : stimulus
		trend_t trend;
		int run_left;
		int counted;
		req_ch.valid = 1'b0;
		req_ch.opcode = '0;
		req_ch.position = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;
		for (int i = 0; i < CAPACITY; i++)
			list_words[i] = '0;

		// empty list: every failing pop/read/remove, find, no-op codes
		add_request(OP_POP_FRONT, 8'd0, 32'sd0);
		add_request(OP_POP_BACK, 8'd0, 32'sd0);
		add_request(OP_READ_FRONT, 8'd0, 32'sd0);
		add_request(OP_READ_BACK, 8'd0, 32'sd0);
		add_request(OP_REMOVE, 8'd0, 32'sd0);
		add_request(OP_FIND, 8'd0, 32'sd0);
		add_request(OP_UNUSED_LO, 8'd255, -32'sd1);
		add_request(OP_UNUSED_HI, 8'd0, 32'sd0);
		// extremes, clamped insert, mid insert
		add_request(OP_PUSH_BACK, 8'd0, 32'sh7FFF_FFFF);
		add_request(OP_PUSH_FRONT, 8'd0, 32'sh8000_0000);
		add_request(OP_INSERT, 8'd255, -32'sd1);
		add_request(OP_INSERT, 8'd1, 32'sd0);
		add_request(OP_READ_FRONT, 8'd0, 32'sd0);
		add_request(OP_READ_BACK, 8'd0, 32'sd0);
		add_request(OP_FIND, 8'd0, -32'sd1);
		add_request(OP_FIND, 8'd0, 32'sd12345);
		add_request(OP_REMOVE, 8'd255, 32'sd0);
		add_request(OP_REMOVE, 8'd4, 32'sd0);
		add_request(OP_REMOVE, 8'd1, 32'sd0);
		add_request(OP_INSERT, 8'd0, 32'sh5555_AAAA);
		add_request(OP_UNUSED_HI, 8'd3, 32'sh1234_5678);
		add_request(OP_READ_BACK, 8'd0, 32'sd0);

		// random part opens with a growth run so the full case comes early
		trend = TREND_GROW;
		run_left = 40;
		counted = 0;
		while (counted < RANDOM_REQS) begin
			if (run_left == 0) begin
				trend = trend_t'($urandom_range(0, 2));
				run_left = $urandom_range(10, 40);
			end
			run_left--;
			if ($urandom_range(0, 29) == 0)
				add_request(4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 8'($urandom),
					$urandom);
			pending_requests.insert(pending_requests.size(), random_request(trend));
			counted++;
		end
		total_reqs = pending_requests.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_reqs < total_reqs || expected_responses.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (errors == 0 && expected_responses.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/iss_pkg.sv
design/iss_if.sv
design/iss_cell.sv
design/indexed_sequence_store_core.sv
bench/tb.sv
